### rtl/core/srl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SYN rate limiter package
// Register indexes, reset values and header constants shared by the design.
// ----------------------------------------------------------------------------
package srl_pkg;

   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W  = 16;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_HIT_LIMIT     = 8'd0,
      CSR_LIMIT_TIMEOUT = 8'd1,
      CSR_RANGE_A_LOW   = 8'd2,
      CSR_RANGE_A_HIGH  = 8'd3,
      CSR_RANGE_B_LOW   = 8'd4,
      CSR_RANGE_B_HIGH  = 8'd5,
      CSR_RANGE_C_LOW   = 8'd6,
      CSR_RANGE_C_HIGH  = 8'd7
   } csr_index_type;

   typedef enum logic {
      OP_PACKET = 1'b0,
      OP_TICK   = 1'b1
   } operation_type;

   localparam logic [15:0] RST_HIT_LIMIT     = 16'd0;
   localparam logic [15:0] RST_LIMIT_TIMEOUT = 16'd180;
   localparam logic [15:0] RST_RANGE_A_LOW   = 16'd0;
   localparam logic [15:0] RST_RANGE_A_HIGH  = 16'hffff;
   localparam logic [15:0] RST_RANGE_B_LOW   = 16'd1;
   localparam logic [15:0] RST_RANGE_B_HIGH  = 16'd0;
   localparam logic [15:0] RST_RANGE_C_LOW   = 16'd1;
   localparam logic [15:0] RST_RANGE_C_HIGH  = 16'd0;

   localparam logic [7:0]  PROTO_TCP       = 8'd6;
   localparam logic [7:0]  LOOPBACK_OCTET  = 8'h7f;
   localparam logic [15:0] MIN_TCP_LENGTH  = 16'd20;

   typedef struct packed {
      logic        operation;
      logic [15:0] packet_length;
      logic [7:0]  protocol;
      logic [3:0]  header_words;
      logic        flag_syn;
      logic        flag_ack;
      logic        flag_rst;
      logic        flag_fin;
      logic [15:0] dest_port;
      logic [31:0] dest_address;
      logic [31:0] source_address;
   } req_word_type;

endpackage

### rtl/core/syn_classifier_source_rate_limiter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SYN classifier with per-source rate limiter
// Classifies parsed TCP/IPv4 headers, limits bare SYNs per source address
// and flags SYNs to monitored destination port ranges.
// ----------------------------------------------------------------------------
// Usage: a word on the req_ channel is either a packet header or a one-second
// tick. Every packet with a non-zero length yields one rsp_ word carrying the
// verdict and any request event; ticks and zero-length packets yield none.
// The csr_ channel writes the eight 16-bit registers and is always ready; the
// user must see that it is written only while the block holds no word; the block itself does not enforce this.
// An accepted req_ word sits in the input register, and the source table
// compare and update run between it and the result register, which drives
// rsp_valid. One word is taken every cycle while the result register is not
// held by low rsp_ready; the source table lookup and update are written back
// as the word moves on, so they complete before the next word reaches them.
// When rsp_ready is low the result register holds its word. The input register
// then holds the word behind it, or takes one more word if it is empty, and
// req_ready stays low until rsp_ready returns. Reset empties both registers,
// invalidates every table entry, zeroes the second counter and restores the
// register defaults.
// ----------------------------------------------------------------------------
module syn_classifier_source_rate_limiter #(
   parameter int SOURCE_ENTRIES = 16
) (
   input  logic                             clock,
   input  logic                             reset,

   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_operation,
   input  logic [15:0]                      req_packet_length,
   input  logic [7:0]                       req_protocol,
   input  logic [3:0]                       req_header_words,
   input  logic                             req_flag_syn,
   input  logic                             req_flag_ack,
   input  logic                             req_flag_rst,
   input  logic                             req_flag_fin,
   input  logic [15:0]                      req_dest_port,
   input  logic [31:0]                      req_dest_address,
   input  logic [31:0]                      req_source_address,

   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic                             rsp_verdict,
   output logic                             rsp_request_event,
   output logic [31:0]                      rsp_event_address,
   output logic [15:0]                      rsp_event_port,

   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [srl_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [srl_pkg::CSR_DATA_W-1:0]   csr_data
);

   import srl_pkg::*;

   localparam int IDX_W = (SOURCE_ENTRIES > 1) ? $clog2(SOURCE_ENTRIES) : 1;

   logic [15:0] hit_limit_ff, limit_timeout_ff;
   logic [15:0] range_a_low_ff, range_a_high_ff;
   logic [15:0] range_b_low_ff, range_b_high_ff;
   logic [15:0] range_c_low_ff, range_c_high_ff;

   req_word_type stage_word_ff;
   logic         stage_valid_ff;
   logic         stage_fire;

   logic [SOURCE_ENTRIES-1:0] entry_valid_ff, entry_valid_in;
   logic [31:0]               entry_address_ff [SOURCE_ENTRIES];
   logic [15:0]               entry_hits_ff    [SOURCE_ENTRIES];
   logic [31:0]               entry_stamp_ff   [SOURCE_ENTRIES];
   logic [31:0]               now_seconds_ff, now_seconds_in;

   logic        rsp_valid_ff;
   logic        rsp_verdict_ff, rsp_request_event_ff;
   logic [31:0] rsp_event_address_ff;
   logic [15:0] rsp_event_port_ff;

   logic [SOURCE_ENTRIES-1:0] match_vec;
   logic                      hit_found, free_found;
   logic [IDX_W-1:0]          hit_idx, free_idx;
   logic                      is_packet, is_tick, candidate, limiting;
   logic                      over_limit, port_hit, verdict, request_event;
   logic                      bump_hits, new_entry;
   logic [15:0]               min_length;
   logic [15:0]               hit_count;

   // Configuration registers.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_limit_ff     <= RST_HIT_LIMIT;
         limit_timeout_ff <= RST_LIMIT_TIMEOUT;
         range_a_low_ff   <= RST_RANGE_A_LOW;
         range_a_high_ff  <= RST_RANGE_A_HIGH;
         range_b_low_ff   <= RST_RANGE_B_LOW;
         range_b_high_ff  <= RST_RANGE_B_HIGH;
         range_c_low_ff   <= RST_RANGE_C_LOW;
         range_c_high_ff  <= RST_RANGE_C_HIGH;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_HIT_LIMIT:     hit_limit_ff     <= csr_data;
            CSR_LIMIT_TIMEOUT: limit_timeout_ff <= csr_data;
            CSR_RANGE_A_LOW:   range_a_low_ff   <= csr_data;
            CSR_RANGE_A_HIGH:  range_a_high_ff  <= csr_data;
            CSR_RANGE_B_LOW:   range_b_low_ff   <= csr_data;
            CSR_RANGE_B_HIGH:  range_b_high_ff  <= csr_data;
            CSR_RANGE_C_LOW:   range_c_low_ff   <= csr_data;
            CSR_RANGE_C_HIGH:  range_c_high_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   // Input register.
   assign stage_fire = stage_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready  = !stage_valid_ff || stage_fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else if (req_ready) begin
         stage_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         stage_word_ff <= '{
            operation:      req_operation,
            packet_length:  req_packet_length,
            protocol:       req_protocol,
            header_words:   req_header_words,
            flag_syn:       req_flag_syn,
            flag_ack:       req_flag_ack,
            flag_rst:       req_flag_rst,
            flag_fin:       req_flag_fin,
            dest_port:      req_dest_port,
            dest_address:   req_dest_address,
            source_address: req_source_address
         };
      end
   end

   // Classification and table lookup.
   always_comb begin
      is_tick    = stage_word_ff.operation == OP_TICK;
      is_packet  = (stage_word_ff.operation == OP_PACKET) &&
                   (stage_word_ff.packet_length != 16'd0);
      min_length = {10'd0, stage_word_ff.header_words, 2'b00} + MIN_TCP_LENGTH;
      candidate  = (stage_word_ff.packet_length >= MIN_TCP_LENGTH) &&
                   (stage_word_ff.protocol == PROTO_TCP) &&
                   (stage_word_ff.packet_length >= min_length) &&
                   stage_word_ff.flag_syn && !stage_word_ff.flag_ack &&
                   !stage_word_ff.flag_rst && !stage_word_ff.flag_fin &&
                   (stage_word_ff.dest_address[31:24] != LOOPBACK_OCTET);
      limiting   = hit_limit_ff != 16'd0;
   end

   always_comb begin
      hit_found  = 1'b0;
      free_found = 1'b0;
      hit_idx    = '0;
      free_idx   = '0;
      for (int i = SOURCE_ENTRIES - 1; i >= 0; i--) begin
         match_vec[i] = entry_valid_ff[i] &&
                        (entry_address_ff[i] == stage_word_ff.source_address);
         if (match_vec[i]) begin
            hit_found = 1'b1;
            hit_idx   = IDX_W'(i);
         end
         if (!entry_valid_ff[i]) begin
            free_found = 1'b1;
            free_idx   = IDX_W'(i);
         end
      end
   end

   always_comb begin
      hit_count     = entry_hits_ff[hit_idx];
      over_limit    = hit_found && (hit_count >= hit_limit_ff);
      port_hit      = ((stage_word_ff.dest_port >= range_a_low_ff) &&
                       (stage_word_ff.dest_port <= range_a_high_ff)) ||
                      ((stage_word_ff.dest_port >= range_b_low_ff) &&
                       (stage_word_ff.dest_port <= range_b_high_ff)) ||
                      ((stage_word_ff.dest_port >= range_c_low_ff) &&
                       (stage_word_ff.dest_port <= range_c_high_ff));
      verdict       = candidate && limiting && over_limit;
      request_event = candidate && !verdict && port_hit;
      bump_hits     = stage_fire && is_packet && candidate && limiting &&
                      hit_found && !over_limit;
      new_entry     = stage_fire && is_packet && candidate && limiting &&
                      !hit_found && free_found;
   end

   // Table update and expiry on ticks.
   always_comb begin
      now_seconds_in = now_seconds_ff;
      entry_valid_in = entry_valid_ff;
      if (stage_fire && is_tick) begin
         now_seconds_in = now_seconds_ff + 32'd1;
         for (int i = 0; i < SOURCE_ENTRIES; i++) begin
            if ((now_seconds_in - entry_stamp_ff[i]) > {16'd0, limit_timeout_ff}) begin
               entry_valid_in[i] = 1'b0;
            end
         end
      end else if (new_entry) begin
         entry_valid_in[free_idx] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= '0;
         now_seconds_ff <= '0;
      end else begin
         entry_valid_ff <= entry_valid_in;
         now_seconds_ff <= now_seconds_in;
      end
   end

   always_ff @(posedge clock) begin
      if (new_entry) begin
         entry_address_ff[free_idx] <= stage_word_ff.source_address;
         entry_hits_ff[free_idx]    <= 16'd1;
         entry_stamp_ff[free_idx]   <= now_seconds_ff;
      end else if (bump_hits) begin
         entry_hits_ff[hit_idx] <= hit_count + 16'd1;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (stage_fire) begin
         rsp_valid_ff <= is_packet;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_fire && is_packet) begin
         rsp_verdict_ff       <= verdict;
         rsp_request_event_ff <= request_event;
         rsp_event_address_ff <= request_event ? stage_word_ff.dest_address : 32'd0;
         rsp_event_port_ff    <= request_event ? stage_word_ff.dest_port : 16'd0;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_verdict       = rsp_verdict_ff;
   assign rsp_request_event = rsp_request_event_ff;
   assign rsp_event_address = rsp_event_address_ff;
   assign rsp_event_port    = rsp_event_port_ff;

endmodule
